// ===== rtl/crohe_pkg.sv =====
`default_nettype none
package crohe_pkg;

	localparam int COLUMNS  = 16;
	localparam int MAX_SPAN = 64;

	localparam int COL_W    = 4;
	localparam int VAL_W    = 16;
	localparam int SPAN_W   = 7;
	localparam int ONEHOT_W = 64;
	localparam int OP_W     = 2;

	// only columns 0..15 can be addressed by a 4-bit field
	localparam int NCOL  = (COLUMNS < (1 << COL_W)) ? COLUMNS : (1 << COL_W);
	localparam int IDX_W = (NCOL > 1) ? $clog2(NCOL) : 1;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = 3;

	localparam logic signed [VAL_W-1:0] VAL_HIGH = 16'sh7FFF;
	localparam logic signed [VAL_W-1:0] VAL_LOW  = 16'sh8000;

	localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
	localparam logic [OP_W-1:0] OP_OBSERVE = 2'd1;
	localparam logic [OP_W-1:0] OP_ENCODE  = 2'd2;

	typedef enum logic [1:0] {
		KIND_CLEAR,
		KIND_OBSERVE,
		KIND_ENCODE
	} kind_t;

	typedef struct packed {
		kind_t                    kind;
		logic                     col_ok;
		logic [COL_W-1:0]         column;
		logic signed [VAL_W-1:0]  value;
	} cmd_t;

endpackage
`default_nettype wire

// ===== rtl/column_range_one_hot_encoder_top.sv =====
`default_nettype none
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: column, value; tuser: op
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: onehot, span; tuser: too_wide
//
// One beat per cycle in and out while neither side stalls. An encode beat passes through
// queue write, range snapshot, then segment build into the output register.
// The range table does one column read-modify-write per beat; clear resets every column together.
// Reset empties every column range. A four-entry queue lets s_axis keep taking beats
// while m_axis stalls; s_axis_tready drops only when the queue is full.
module column_range_one_hot_encoder_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // column[3:0], value[19:4], zero pad
	input  wire logic [1:0]  s_axis_tuser,   // op[1:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [71:0]      m_axis_tdata,   // onehot[63:0], span[70:64], zero pad
	output logic [0:0]       m_axis_tuser    // too_wide[0]
);

	logic            fq_valid;
	logic            fq_ready;
	crohe_pkg::cmd_t fq_cmd;
	logic            qb_valid;
	logic            qb_ready;
	crohe_pkg::cmd_t qb_cmd;

	crohe_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.push_valid    (fq_valid),
		.push_ready    (fq_ready),
		.push_cmd      (fq_cmd)
	);

	crohe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_cmd    (fq_cmd),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_cmd   (qb_cmd)
	);

	crohe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (qb_valid),
		.cmd_ready     (qb_ready),
		.cmd           (qb_cmd),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
`default_nettype wire

// ===== rtl/crohe_front.sv =====
`default_nettype none
module crohe_front (
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [23:0]                    s_axis_tdata,
	input  wire logic [crohe_pkg::OP_W-1:0]     s_axis_tuser,
	output logic                                push_valid,
	input  wire logic                           push_ready,
	output crohe_pkg::cmd_t                     push_cmd
);

	logic [crohe_pkg::COL_W-1:0] column;
	logic                        col_ok;
	logic                        keep;

	assign column = s_axis_tdata[crohe_pkg::COL_W-1:0];
	assign col_ok = ({1'b0, column} < (crohe_pkg::COL_W+1)'(crohe_pkg::NCOL));

	always_comb begin
		push_cmd.col_ok = col_ok;
		push_cmd.column = column;
		push_cmd.value  = s_axis_tdata[crohe_pkg::COL_W +: crohe_pkg::VAL_W];
		keep            = 1'b1;
		unique case (s_axis_tuser)
			crohe_pkg::OP_CLEAR: begin
				push_cmd.kind = crohe_pkg::KIND_CLEAR;
			end
			crohe_pkg::OP_OBSERVE: begin
				push_cmd.kind = crohe_pkg::KIND_OBSERVE;
				keep          = col_ok;
			end
			crohe_pkg::OP_ENCODE: begin
				push_cmd.kind = crohe_pkg::KIND_ENCODE;
			end
			default: begin
				// unused op: swallow the beat
				push_cmd.kind = crohe_pkg::KIND_CLEAR;
				keep          = 1'b0;
			end
		endcase
	end

	assign s_axis_tready = push_ready;
	assign push_valid    = s_axis_tvalid & keep;

endmodule
`default_nettype wire

// ===== rtl/crohe_queue.sv =====
`default_nettype none
module crohe_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire crohe_pkg::cmd_t in_cmd,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output crohe_pkg::cmd_t      out_cmd
);

	crohe_pkg::cmd_t                  mem_q [crohe_pkg::Q_DEPTH];
	logic [crohe_pkg::Q_PTR_W-1:0]    wr_ptr_q;
	logic [crohe_pkg::Q_PTR_W-1:0]    rd_ptr_q;
	logic [crohe_pkg::Q_CNT_W-1:0]    count_q;
	logic                             push;
	logic                             pop;

	assign in_ready  = (count_q != crohe_pkg::Q_CNT_W'(crohe_pkg::Q_DEPTH));
	assign out_valid = (count_q != '0);
	assign push      = in_valid & in_ready;
	assign pop       = out_valid & out_ready;
	assign out_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/crohe_back.sv =====
`default_nettype none
module crohe_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_valid,
	output logic                 cmd_ready,
	input  wire crohe_pkg::cmd_t cmd,
	output logic                 m_axis_tvalid,
	input  wire logic            m_axis_tready,
	output logic [71:0]          m_axis_tdata,
	output logic [0:0]           m_axis_tuser
);

	logic signed [crohe_pkg::VAL_W-1:0] min_q [crohe_pkg::NCOL];
	logic signed [crohe_pkg::VAL_W-1:0] max_q [crohe_pkg::NCOL];

	logic [crohe_pkg::IDX_W-1:0]        idx;
	logic                               pop;
	logic                               valid_s1;
	logic                               adv;
	logic                               s1_ready;
	logic signed [crohe_pkg::VAL_W-1:0] lo_s1;
	logic signed [crohe_pkg::VAL_W-1:0] hi_s1;
	logic signed [crohe_pkg::VAL_W-1:0] val_s1;
	logic                               ok_s1;

	logic signed [crohe_pkg::VAL_W+1:0] width;
	logic signed [crohe_pkg::VAL_W+1:0] offset;
	logic                               nonempty;
	logic                               wide;
	logic                               hit;
	logic [crohe_pkg::ONEHOT_W-1:0]     onehot_d;
	logic [crohe_pkg::SPAN_W-1:0]       span_d;

	logic                               out_valid_q;
	logic [crohe_pkg::ONEHOT_W-1:0]     onehot_q;
	logic [crohe_pkg::SPAN_W-1:0]       span_q;
	logic                               wide_q;

	assign idx       = cmd.column[crohe_pkg::IDX_W-1:0];
	assign adv       = valid_s1 & (~out_valid_q | m_axis_tready);
	assign s1_ready  = ~valid_s1 | adv;
	assign cmd_ready = (cmd.kind != crohe_pkg::KIND_ENCODE) | s1_ready;
	assign pop       = cmd_valid & cmd_ready;

	// range table: read-modify-write of one column per observe beat; clear resets every column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < crohe_pkg::NCOL; i++) begin
				min_q[i] <= crohe_pkg::VAL_HIGH;
				max_q[i] <= crohe_pkg::VAL_LOW;
			end
		end else if (pop) begin
			priority if (cmd.kind == crohe_pkg::KIND_CLEAR) begin
				for (int i = 0; i < crohe_pkg::NCOL; i++) begin
					min_q[i] <= crohe_pkg::VAL_HIGH;
					max_q[i] <= crohe_pkg::VAL_LOW;
				end
			end else if (cmd.kind == crohe_pkg::KIND_OBSERVE && cmd.col_ok) begin
				if (cmd.value < min_q[idx]) begin
					min_q[idx] <= cmd.value;
				end
				if (cmd.value > max_q[idx]) begin
					max_q[idx] <= cmd.value;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pop && cmd.kind == crohe_pkg::KIND_ENCODE) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && cmd.kind == crohe_pkg::KIND_ENCODE) begin
			lo_s1  <= min_q[idx];
			hi_s1  <= max_q[idx];
			val_s1 <= cmd.value;
			ok_s1  <= cmd.col_ok;
		end
	end

	// segment build from the captured range
	always_comb begin
		width    = (crohe_pkg::VAL_W+2)'(hi_s1) - (crohe_pkg::VAL_W+2)'(lo_s1)
			+ (crohe_pkg::VAL_W+2)'(1);
		offset   = (crohe_pkg::VAL_W+2)'(val_s1) - (crohe_pkg::VAL_W+2)'(lo_s1);
		nonempty = ok_s1 & (lo_s1 <= hi_s1);
		wide     = nonempty & (width > (crohe_pkg::VAL_W+2)'(crohe_pkg::MAX_SPAN));
		hit      = nonempty & ~wide & (val_s1 >= lo_s1) & (val_s1 <= hi_s1);
		span_d   = (nonempty && !wide) ? width[crohe_pkg::SPAN_W-1:0] : '0;
		onehot_d = hit ? (crohe_pkg::ONEHOT_W'(1) << offset[5:0]) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			onehot_q <= onehot_d;
			span_q   <= span_d;
			wide_q   <= wide;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, span_q, onehot_q};
	assign m_axis_tuser  = wide_q;

endmodule
`default_nettype wire
